// ===== src/gol_pkg.sv =====
// Shared constants, request codes and memory port types of the Game of Life grid engine.
`default_nettype none

package gol_pkg;

   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);

   localparam int CFG_W     = 7;
   localparam int CFG_IDX_W = 1;
   localparam int COORD_W   = 6;

   localparam logic [CFG_W-1:0] CFG_DIM_RESET = CFG_W'(64);

   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_READ  = 2'd1,
      REQ_STEP  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [CFG_IDX_W-1:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_code_type;

   typedef logic [MAX_WIDTH-1:0] row_type;

   typedef struct packed {
      logic             wr_en;
      logic [ROW_W-1:0] wr_addr;
      row_type          wr_data;
      logic             rd_en;
      logic [ROW_W-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== src/gol_row_mem.sv =====
// Grid store: one row of cells per entry, one write and one registered read per cycle.
`default_nettype none

module gol_row_mem (
   input  wire                       clock,
   input  wire gol_pkg::mem_req_type mem_req,
   output gol_pkg::row_type          rd_data
);
   import gol_pkg::*;

   row_type mem [MAX_HEIGHT];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/gol_rule_unit.sv =====
// Neighbour count and Conway rule for a single cell.
`default_nettype none

module gol_rule_unit (
   input  wire [7:0] neighbours,
   input  wire       self_alive,
   output logic      next_alive
);
   logic [3:0] count;

   assign count      = 4'($countones(neighbours));
   assign next_alive = (count == 4'd3) || ((count == 4'd2) && self_alive);

endmodule

`default_nettype wire

// ===== src/game_of_life_grid_engine.sv =====
// Top level of the Game of Life grid engine: request sequencer, row window and result register.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  req_type, req_x_coord, req_y_coord, req_cell_in
//   rsp_      out        rsp_valid/rsp_ready  rsp_cell_out, rsp_status
//   csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A read passes through ST_RD and a write through ST_WR before ST_RESP; an ignored request
// goes straight to ST_RESP. A generation sweeps the active w by h grid row by row; the
// shared rule unit evaluates one cell a cycle; each row visits ST_G_BELOW and ST_G_WRITE.
// After reset a clearing pass writes all MAX_HEIGHT rows dead, with req_ready low.
// A finished item waits in the result register while the next item is accepted.
`default_nettype none

module game_of_life_grid_engine (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire [1:0]                      req_type,
   input  wire [gol_pkg::COORD_W-1:0]     req_x_coord,
   input  wire [gol_pkg::COORD_W-1:0]     req_y_coord,
   input  wire                            req_cell_in,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic                           rsp_cell_out,
   output logic                           rsp_status,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire [gol_pkg::CFG_IDX_W-1:0]   csr_index,
   input  wire [gol_pkg::CFG_W-1:0]       csr_wdata
);
   import gol_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD,
      ST_WR,
      ST_G_MID,
      ST_G_BELOW,
      ST_G_CELL,
      ST_G_WRITE,
      ST_RESP
   } state_type;

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic             cell_ff, cell_in;
   row_type          above_ff, above_in;
   row_type          mid_ff, mid_in;
   row_type          below_ff, below_in;
   row_type          new_ff, new_in;
   logic             res_cell_ff, res_cell_in;
   logic             res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_cell_ff, rsp_cell_in;
   logic             rsp_status_ff, rsp_status_in;
   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;

   logic [WDIM_W-1:0] act_w;
   logic [HDIM_W-1:0] act_h;
   logic              coord_ok;
   mem_req_type       mem_req;
   row_type           rd_data;

   logic [COL_W-1:0] left_idx, right_idx;
   logic             left_ok, right_ok;
   logic [7:0]       neighbours;
   logic             next_alive;
   logic             last_col, last_row, below_in_grid, far_in_grid;

   // Zero counts as one, anything above the maximum saturates.
   always_comb begin
      if (width_ff == '0) begin
         act_w = WDIM_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         act_w = WDIM_W'(MAX_WIDTH);
      end else begin
         act_w = WDIM_W'(width_ff);
      end
      if (height_ff == '0) begin
         act_h = HDIM_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         act_h = HDIM_W'(MAX_HEIGHT);
      end else begin
         act_h = HDIM_W'(height_ff);
      end
   end

   assign coord_ok = (32'(req_x_coord) < 32'(act_w)) && (32'(req_y_coord) < 32'(act_h));

   // Neighbour window around the current column; columns outside the grid read as dead.
   assign left_idx  = col_ff - COL_W'(1);
   assign right_idx = col_ff + COL_W'(1);
   assign left_ok   = (col_ff != '0);
   assign right_ok  = (32'(col_ff) + 32'd1) < 32'(act_w);
   assign neighbours = {above_ff[left_idx] & left_ok, above_ff[col_ff],
                        above_ff[right_idx] & right_ok,
                        mid_ff[left_idx] & left_ok, mid_ff[right_idx] & right_ok,
                        below_ff[left_idx] & left_ok, below_ff[col_ff],
                        below_ff[right_idx] & right_ok};

   assign last_col      = (32'(col_ff) + 32'd1) == 32'(act_w);
   assign last_row      = (32'(row_ff) + 32'd1) == 32'(act_h);
   assign below_in_grid = (32'(row_ff) + 32'd1) < 32'(act_h);
   assign far_in_grid   = (32'(row_ff) + 32'd2) < 32'(act_h);

   gol_rule_unit u_rule (
      .neighbours (neighbours),
      .self_alive (mid_ff[col_ff]),
      .next_alive (next_alive)
   );

   gol_row_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      cell_in       = cell_ff;
      above_in      = above_ff;
      mid_in        = mid_ff;
      below_in      = below_ff;
      new_in        = new_ff;
      res_cell_in   = res_cell_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_cell_in   = rsp_cell_ff;
      rsp_status_in = rsp_status_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      mem_req       = '0;

      if (csr_valid) begin
         unique case (csr_code_type'(csr_index))
            CSR_WIDTH:  width_in  = csr_wdata;
            CSR_HEIGHT: height_in = csr_wdata;
            default:    width_in  = width_ff;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = row_ff;
            mem_req.wr_data = '0;
            if (32'(row_ff) == (MAX_HEIGHT - 1)) begin
               row_in   = '0;
               state_in = ST_IDLE;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               x_in          = req_x_coord;
               y_in          = req_y_coord;
               cell_in       = req_cell_in;
               res_cell_in   = 1'b0;
               res_status_in = 1'b0;
               case (req_code_type'(req_type)) inside
                  REQ_WRITE, REQ_READ: begin
                     if (coord_ok) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = ROW_W'(req_y_coord);
                        state_in = (req_code_type'(req_type) == REQ_WRITE) ? ST_WR : ST_RD;
                     end else begin
                        res_status_in = 1'b1;
                        state_in      = ST_RESP;
                     end
                  end
                  REQ_STEP: begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = '0;
                     row_in          = '0;
                     above_in        = '0;
                     state_in        = ST_G_MID;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_RD: begin
            res_cell_in = rd_data[COL_W'(x_ff)];
            state_in    = ST_RESP;
         end
         ST_WR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = ROW_W'(y_ff);
            mem_req.wr_data = rd_data;
            mem_req.wr_data[COL_W'(x_ff)] = cell_ff;
            state_in = ST_RESP;
         end
         ST_G_MID: begin
            mid_in = rd_data;
            new_in = rd_data;
            if (below_in_grid) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = row_ff + ROW_W'(1);
            end
            state_in = ST_G_BELOW;
         end
         ST_G_BELOW: begin
            below_in = below_in_grid ? rd_data : '0;
            col_in   = '0;
            state_in = ST_G_CELL;
         end
         ST_G_CELL: begin
            new_in[col_ff] = next_alive;
            if (last_col) begin
               state_in = ST_G_WRITE;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_G_WRITE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = row_ff;
            mem_req.wr_data = new_ff;
            if (last_row) begin
               state_in = ST_RESP;
            end else begin
               // The row two below is still unwritten, so it is read before this sweep reaches it.
               above_in = mid_ff;
               mid_in   = below_ff;
               new_in   = below_ff;
               row_in   = row_ff + ROW_W'(1);
               if (far_in_grid) begin
                  mem_req.rd_en   = 1'b1;
                  mem_req.rd_addr = row_ff + ROW_W'(2);
               end
               state_in = ST_G_BELOW;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_cell_in   = res_cell_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= CFG_DIM_RESET;
         height_ff    <= CFG_DIM_RESET;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
      end
      col_ff        <= col_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      cell_ff       <= cell_in;
      above_ff      <= above_in;
      mid_ff        <= mid_in;
      below_ff      <= below_in;
      new_ff        <= new_in;
      res_cell_ff   <= res_cell_in;
      res_status_ff <= res_status_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_cell_out = rsp_cell_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

`default_nettype wire
